[hw/rtl/pcp_pkg.sv]
// Shared types and constants for the polyline closest-point block.
package pcp_pkg;

  // command codes
  localparam logic [1:0] CMD_CLEAR  = 2'd0;
  localparam logic [1:0] CMD_APPEND = 2'd1;
  localparam logic [1:0] CMD_QUERY  = 2'd2;

  // accumulator wide enough for a sum of three squared 50-bit magnitudes
  localparam int ACC_W = 104;
  // squared segment length and division remainder
  localparam int LEN_W = 70;
  // vertex entry: x, y, z, cumulative length
  localparam int ENTRY_W = 128;

  localparam logic [31:0] M32    = 32'hffff_ffff;
  localparam logic [62:0] SQ_MAX = 63'h7fff_ffff_ffff_ffff;
  localparam logic [16:0] T_ONE  = 17'h1_0000;

  typedef logic [ACC_W-1:0] acc_t;

  typedef struct packed {
    logic start;
    logic clear;
    logic neg;
  } mac_ctl_t;

  function automatic logic [63:0] mag33(input logic signed [32:0] v);
    logic [63:0] ext;
    ext = {{31{v[32]}}, v};
    return v[32] ? (64'd0 - ext) : ext;
  endfunction

  function automatic logic [63:0] mag52(input logic signed [51:0] v);
    logic [63:0] ext;
    ext = {{12{v[51]}}, v};
    return v[51] ? (64'd0 - ext) : ext;
  endfunction

endpackage

[hw/rtl/polyline_closest_point.sv]
// Top level: 3D polyline store and nearest-point search.
// Usage:
//   Input channel (in_valid/in_ready) carries one item: in_cmd plus a point.
//   CLEAR empties the polyline, APPEND stores a vertex (dropped when full),
//   QUERY returns one result item on the out_ channel. CLEAR, APPEND and the
//   unused command give no result.
//   cfg_wr_en/cfg_wr_data set closed_loop, which adds the closing segment.
//   Write it only while the block is idle.
// Timing: one item at a time. An append holds the input for three
//   multiply-accumulates and a square root; the root is skipped when the
//   length saturates. A query searches each segment with two vertex reads
//   plus nine multiply-accumulates (four 32x32 partial products each) on
//   the shared multiplier and a 16-step divide, which is skipped when t clamps.
//   Then it forms arc position and distance, with one more square root when
//   the winner is the closing segment. A query on fewer than two vertices
//   goes straight to the output step.
// Reset: rst_n (synchronous, active low) empties the polyline, clears
//   closed_loop and drops any pending result. Vertex RAM is not cleared.
// Stall: a finished result waits in the output register; the next item is
//   taken meanwhile, and a following query holds in its last step until the
//   output register frees up.
module polyline_closest_point #(
  parameter int MAX_POINTS = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic        cfg_wr_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_cmd,
  input  logic signed [31:0] in_point_x,
  input  logic signed [31:0] in_point_y,
  input  logic signed [31:0] in_point_z,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_line_valid,
  output logic [7:0]  out_seg_index,
  output logic [16:0] out_seg_frac,
  output logic [62:0] out_dist_sq,
  output logic [31:0] out_dist_res,
  output logic [31:0] out_arc_pos
);
  import pcp_pkg::*;

  localparam int CNT_W = $clog2(MAX_POINTS + 1);
  localparam int AW    = $clog2(MAX_POINTS);

  typedef enum logic [19:0] {
    ST_IDLE   = 20'h00001,
    ST_AP_RD  = 20'h00002,
    ST_AP_MAC = 20'h00004,
    ST_AP_SQ  = 20'h00008,
    ST_AP_WR  = 20'h00010,
    ST_Q_RDA  = 20'h00020,
    ST_Q_RDB  = 20'h00040,
    ST_Q_LOAD = 20'h00080,
    ST_Q_LEN  = 20'h00100,
    ST_Q_DOT  = 20'h00200,
    ST_Q_DIV  = 20'h00400,
    ST_Q_SQ   = 20'h00800,
    ST_F_RDA  = 20'h01000,
    ST_F_RDB  = 20'h02000,
    ST_F_CUM  = 20'h04000,
    ST_F_LEN  = 20'h08000,
    ST_F_ARC  = 20'h10000,
    ST_F_DIST = 20'h20000,
    ST_F_SQRT = 20'h40000,
    ST_OUT    = 20'h80000
  } state_t;

  state_t state_r, state_nxt;

  logic [CNT_W-1:0] count_r, count_nxt;
  logic             closed_r;
  logic [CNT_W-1:0] seg_r, seg_nxt, nseg_r, nseg_nxt;
  logic signed [31:0] q_r [3];
  logic signed [31:0] q_nxt [3];
  logic signed [31:0] a_r [3];
  logic signed [31:0] a_nxt [3];
  logic signed [32:0] d_r [3];
  logic signed [32:0] d_nxt [3];
  logic signed [32:0] w_r [3];
  logic signed [32:0] w_nxt [3];
  logic [1:0]       k_r, k_nxt;
  logic             issued_r, issued_nxt;
  logic [LEN_W-1:0] len_r, len_nxt, rem_r, rem_nxt;
  logic [16:0]      t_r, t_nxt;
  logic [3:0]       div_r, div_nxt;
  acc_t             best_s_r, best_s_nxt;
  logic [CNT_W-1:0] best_i_r, best_i_nxt;
  logic [16:0]      best_t_r, best_t_nxt;
  logic [LEN_W-1:0] best_len_r, best_len_nxt;
  logic [31:0]      cum_a_r, cum_a_nxt, seglen_r, seglen_nxt;
  logic [48:0]      prod_r, prod_nxt;
  logic             line_r, line_nxt;
  logic [62:0]      dsq_r, dsq_nxt;
  logic [31:0]      dres_r, dres_nxt, arc_r, arc_nxt;

  logic             out_valid_r, out_valid_nxt;
  logic             o_line_r, o_line_nxt;
  logic [7:0]       o_idx_r, o_idx_nxt;
  logic [16:0]      o_frac_r, o_frac_nxt;
  logic [62:0]      o_dsq_r, o_dsq_nxt;
  logic [31:0]      o_dres_r, o_dres_nxt, o_arc_r, o_arc_nxt;

  // RAM, MAC and square root hookup
  logic               ram_we;
  logic [AW-1:0]      ram_waddr, ram_raddr;
  logic [ENTRY_W-1:0] ram_wdata, ram_rdata;
  logic signed [31:0] rd_p [3];
  logic [31:0]        rd_cum;
  mac_ctl_t           mac_ctl;
  logic [63:0]        mac_a, mac_b;
  acc_t               mac_acc;
  logic               mac_done, mac_last;
  logic               sq_start, sq_done;
  logic [63:0]        sq_din;
  logic [31:0]        sq_root;

  // helper values
  logic               in_acc;
  logic [CNT_W-1:0]   seg_inc, best_inc;
  logic [AW-1:0]      next_addr;
  logic signed [50:0] dt;
  logic signed [51:0] e_val;
  logic [32:0]        cum_sum;
  logic [33:0]        arc_sum;
  logic [71:0]        sq_val;
  logic [LEN_W:0]     rem2, rem_sub;
  logic               dot_pos;

  assign rd_p[0] = ram_rdata[127:96];
  assign rd_p[1] = ram_rdata[95:64];
  assign rd_p[2] = ram_rdata[63:32];
  assign rd_cum  = ram_rdata[31:0];

  assign in_ready = (state_r == ST_IDLE);
  assign in_acc   = in_valid && in_ready;
  assign mac_last = mac_done && (k_r == 2'd2);
  assign seg_inc  = seg_r + CNT_W'(1);
  assign best_inc = best_i_r + CNT_W'(1);
  assign next_addr = (seg_inc < count_r) ? seg_inc[AW-1:0] : '0;

  // error term of the current axis: w * 2^16 - d * t
  assign dt      = $signed({1'b0, t_r}) * d_r[k_r];
  assign e_val   = $signed({{3{w_r[k_r][32]}}, w_r[k_r], 16'd0}) - $signed({dt[50], dt});
  assign cum_sum = {1'b0, cum_a_r} + {1'b0, seglen_r};
  assign arc_sum = {2'd0, cum_a_r} + {1'b0, prod_r[48:16]};
  assign sq_val  = best_s_r[ACC_W-1:32];
  assign rem2    = {rem_r, 1'b0};
  assign rem_sub = rem2 - {1'b0, len_r};
  assign dot_pos = !mac_acc[ACC_W-1] && (mac_acc != '0);

  always_comb begin
    case (state_r)
      ST_Q_DOT: begin
        mac_a = mag33(d_r[k_r]);
        mac_b = mag33(w_r[k_r]);
      end
      ST_Q_SQ: begin
        mac_a = mag52(e_val);
        mac_b = mag52(e_val);
      end
      default: begin
        mac_a = mag33(d_r[k_r]);
        mac_b = mag33(d_r[k_r]);
      end
    endcase
  end

  always_comb begin
    state_nxt    = state_r;
    count_nxt    = count_r;
    seg_nxt      = seg_r;
    nseg_nxt     = nseg_r;
    q_nxt        = q_r;
    a_nxt        = a_r;
    d_nxt        = d_r;
    w_nxt        = w_r;
    k_nxt        = k_r;
    issued_nxt   = issued_r;
    len_nxt      = len_r;
    rem_nxt      = rem_r;
    t_nxt        = t_r;
    div_nxt      = div_r;
    best_s_nxt   = best_s_r;
    best_i_nxt   = best_i_r;
    best_t_nxt   = best_t_r;
    best_len_nxt = best_len_r;
    cum_a_nxt    = cum_a_r;
    seglen_nxt   = seglen_r;
    prod_nxt     = prod_r;
    line_nxt     = line_r;
    dsq_nxt      = dsq_r;
    dres_nxt     = dres_r;
    arc_nxt      = arc_r;
    out_valid_nxt = out_valid_r && !out_ready;
    o_line_nxt   = o_line_r;
    o_idx_nxt    = o_idx_r;
    o_frac_nxt   = o_frac_r;
    o_dsq_nxt    = o_dsq_r;
    o_dres_nxt   = o_dres_r;
    o_arc_nxt    = o_arc_r;
    ram_we       = 1'b0;
    ram_waddr    = count_r[AW-1:0];
    ram_wdata    = {q_r[0], q_r[1], q_r[2], cum_sum[32] ? M32 : cum_sum[31:0]};
    ram_raddr    = '0;
    mac_ctl      = '0;
    mac_ctl.neg  = (state_r == ST_Q_DOT) && (d_r[k_r][32] != w_r[k_r][32]);
    sq_start     = 1'b0;
    sq_din       = mac_acc[63:0];

    // shared multiply-accumulate stepping over the three axes
    if (state_r == ST_AP_MAC || state_r == ST_Q_LEN || state_r == ST_Q_DOT ||
        state_r == ST_Q_SQ) begin
      if (mac_done) begin
        k_nxt      = (k_r == 2'd2) ? 2'd0 : k_r + 2'd1;
        issued_nxt = 1'b0;
      end else if (!issued_r) begin
        mac_ctl.start = 1'b1;
        issued_nxt    = 1'b1;
      end
    end

    case (state_r)
      ST_IDLE: begin
        ram_raddr = AW'(count_r - CNT_W'(1));
        if (in_acc) begin
          q_nxt[0] = in_point_x;
          q_nxt[1] = in_point_y;
          q_nxt[2] = in_point_z;
          case (in_cmd)
            CMD_CLEAR: begin
              count_nxt = '0;
            end
            CMD_APPEND: begin
              if (count_r != CNT_W'(MAX_POINTS)) begin
                if (count_r == '0) begin
                  ram_we    = 1'b1;
                  ram_wdata = {in_point_x, in_point_y, in_point_z, 32'd0};
                  count_nxt = CNT_W'(1);
                end else begin
                  state_nxt = ST_AP_RD;
                end
              end
            end
            CMD_QUERY: begin
              if (count_r < CNT_W'(2)) begin
                line_nxt   = 1'b0;
                best_i_nxt = '0;
                best_t_nxt = '0;
                dsq_nxt    = '0;
                dres_nxt   = '0;
                arc_nxt    = '0;
                state_nxt  = ST_OUT;
              end else begin
                seg_nxt   = '0;
                nseg_nxt  = count_r - CNT_W'(1) + CNT_W'(closed_r);
                state_nxt = ST_Q_RDA;
              end
            end
            default: begin
              // unused command: drop
            end
          endcase
        end
      end

      ST_AP_RD: begin
        for (int k = 0; k < 3; k++) begin
          d_nxt[k] = {q_r[k][31], q_r[k]} - {rd_p[k][31], rd_p[k]};
        end
        cum_a_nxt     = rd_cum;
        mac_ctl.clear = 1'b1;
        k_nxt         = '0;
        issued_nxt    = 1'b0;
        state_nxt     = ST_AP_MAC;
      end

      ST_AP_MAC: begin
        if (mac_last) begin
          if (mac_acc[ACC_W-1:64] != '0) begin
            seglen_nxt = M32;
            state_nxt  = ST_AP_WR;
          end else begin
            sq_start  = 1'b1;
            state_nxt = ST_AP_SQ;
          end
        end
      end

      ST_AP_SQ: begin
        if (sq_done) begin
          seglen_nxt = sq_root;
          state_nxt  = ST_AP_WR;
        end
      end

      ST_AP_WR: begin
        ram_we    = 1'b1;
        count_nxt = count_r + CNT_W'(1);
        state_nxt = ST_IDLE;
      end

      ST_Q_RDA: begin
        ram_raddr = seg_r[AW-1:0];
        state_nxt = ST_Q_RDB;
      end

      ST_Q_RDB: begin
        ram_raddr = next_addr;
        a_nxt     = rd_p;
        state_nxt = ST_Q_LOAD;
      end

      ST_Q_LOAD: begin
        for (int k = 0; k < 3; k++) begin
          d_nxt[k] = {rd_p[k][31], rd_p[k]} - {a_r[k][31], a_r[k]};
          w_nxt[k] = {q_r[k][31], q_r[k]} - {a_r[k][31], a_r[k]};
        end
        mac_ctl.clear = 1'b1;
        k_nxt         = '0;
        issued_nxt    = 1'b0;
        state_nxt     = ST_Q_LEN;
      end

      ST_Q_LEN: begin
        if (mac_last) begin
          len_nxt       = mac_acc[LEN_W-1:0];
          mac_ctl.clear = 1'b1;
          state_nxt     = ST_Q_DOT;
        end
      end

      ST_Q_DOT: begin
        if (mac_last) begin
          mac_ctl.clear = 1'b1;
          t_nxt         = '0;
          if (len_r == '0 || !dot_pos) begin
            state_nxt = ST_Q_SQ;
          end else if (mac_acc >= ACC_W'(len_r)) begin
            t_nxt     = T_ONE;
            state_nxt = ST_Q_SQ;
          end else begin
            rem_nxt   = mac_acc[LEN_W-1:0];
            div_nxt   = '0;
            state_nxt = ST_Q_DIV;
          end
        end
      end

      ST_Q_DIV: begin
        // one quotient bit per cycle
        if (!rem_sub[LEN_W]) begin
          rem_nxt = rem_sub[LEN_W-1:0];
          t_nxt   = {t_r[15:0], 1'b1};
        end else begin
          rem_nxt = rem2[LEN_W-1:0];
          t_nxt   = {t_r[15:0], 1'b0};
        end
        div_nxt = div_r + 4'd1;
        if (div_r == 4'd15) begin
          state_nxt = ST_Q_SQ;
        end
      end

      ST_Q_SQ: begin
        if (mac_last) begin
          mac_ctl.clear = 1'b1;
          if (seg_r == '0 || mac_acc < best_s_r) begin
            best_s_nxt   = mac_acc;
            best_i_nxt   = seg_r;
            best_t_nxt   = t_r;
            best_len_nxt = len_r;
          end
          if (seg_inc == nseg_r) begin
            state_nxt = ST_F_RDA;
          end else begin
            seg_nxt   = seg_inc;
            state_nxt = ST_Q_RDA;
          end
        end
      end

      ST_F_RDA: begin
        ram_raddr = best_i_r[AW-1:0];
        state_nxt = ST_F_RDB;
      end

      ST_F_RDB: begin
        ram_raddr = best_inc[AW-1:0];
        cum_a_nxt = rd_cum;
        state_nxt = ST_F_CUM;
      end

      ST_F_CUM: begin
        if (best_inc < count_r) begin
          seglen_nxt = rd_cum - cum_a_r;
          state_nxt  = ST_F_ARC;
        end else if (best_len_r[LEN_W-1:64] != '0) begin
          seglen_nxt = M32;
          state_nxt  = ST_F_ARC;
        end else begin
          // closing segment: take its own length
          sq_start  = 1'b1;
          sq_din    = best_len_r[63:0];
          state_nxt = ST_F_LEN;
        end
      end

      ST_F_LEN: begin
        if (sq_done) begin
          seglen_nxt = sq_root;
          state_nxt  = ST_F_ARC;
        end
      end

      ST_F_ARC: begin
        prod_nxt  = 49'(seglen_r * best_t_r);
        state_nxt = ST_F_DIST;
      end

      ST_F_DIST: begin
        line_nxt = 1'b1;
        arc_nxt  = (arc_sum[33:32] != 2'd0) ? M32 : arc_sum[31:0];
        dsq_nxt  = (sq_val[71:63] != '0) ? SQ_MAX : sq_val[62:0];
        if (sq_val[71:64] != '0) begin
          dres_nxt  = M32;
          state_nxt = ST_OUT;
        end else begin
          sq_start  = 1'b1;
          sq_din    = sq_val[63:0];
          state_nxt = ST_F_SQRT;
        end
      end

      ST_F_SQRT: begin
        if (sq_done) begin
          dres_nxt  = sq_root;
          state_nxt = ST_OUT;
        end
      end

      ST_OUT: begin
        // hold until the output register is free
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          o_line_nxt    = line_r;
          o_idx_nxt     = 8'(best_i_r);
          o_frac_nxt    = best_t_r;
          o_dsq_nxt     = dsq_r;
          o_dres_nxt    = dres_r;
          o_arc_nxt     = arc_r;
          state_nxt     = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      closed_r    <= 1'b0;
      out_valid_r <= 1'b0;
      issued_r    <= 1'b0;
      k_r         <= '0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
      issued_r    <= issued_nxt;
      k_r         <= k_nxt;
      if (cfg_wr_en) begin
        closed_r <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    seg_r      <= seg_nxt;
    nseg_r     <= nseg_nxt;
    q_r        <= q_nxt;
    a_r        <= a_nxt;
    d_r        <= d_nxt;
    w_r        <= w_nxt;
    len_r      <= len_nxt;
    rem_r      <= rem_nxt;
    t_r        <= t_nxt;
    div_r      <= div_nxt;
    best_s_r   <= best_s_nxt;
    best_i_r   <= best_i_nxt;
    best_t_r   <= best_t_nxt;
    best_len_r <= best_len_nxt;
    cum_a_r    <= cum_a_nxt;
    seglen_r   <= seglen_nxt;
    prod_r     <= prod_nxt;
    line_r     <= line_nxt;
    dsq_r      <= dsq_nxt;
    dres_r     <= dres_nxt;
    arc_r      <= arc_nxt;
    o_line_r   <= o_line_nxt;
    o_idx_r    <= o_idx_nxt;
    o_frac_r   <= o_frac_nxt;
    o_dsq_r    <= o_dsq_nxt;
    o_dres_r   <= o_dres_nxt;
    o_arc_r    <= o_arc_nxt;
  end

  pcp_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (MAX_POINTS)
  ) u_vert_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  pcp_mac u_mac (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (mac_ctl),
    .op_a  (mac_a),
    .op_b  (mac_b),
    .acc   (mac_acc),
    .done  (mac_done)
  );

  pcp_isqrt u_isqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .start (sq_start),
    .din   (sq_din),
    .root  (sq_root),
    .done  (sq_done)
  );

  assign out_valid      = out_valid_r;
  assign out_line_valid = o_line_r;
  assign out_seg_index  = o_idx_r;
  assign out_seg_frac   = o_frac_r;
  assign out_dist_sq    = o_dsq_r;
  assign out_dist_res   = o_dres_r;
  assign out_arc_pos    = o_arc_r;

endmodule

[hw/rtl/pcp_ram.sv]
// Generic single-port-write, registered-read RAM.
module pcp_ram #(
  parameter int WIDTH = 128,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

[hw/rtl/pcp_mac.sv]
// Multi-cycle 64x64 multiply-accumulate built from one 32x32 multiplier.
module pcp_mac (
  input  logic             clk,
  input  logic             rst_n,
  input  pcp_pkg::mac_ctl_t ctl,
  input  logic [63:0]      op_a,
  input  logic [63:0]      op_b,
  output pcp_pkg::acc_t    acc,
  output logic             done
);
  import pcp_pkg::*;

  logic [63:0]  a_r, b_r;
  logic         neg_r;
  logic [2:0]   ph_r;
  logic         busy_r, done_r;
  logic [63:0]  p_r;
  logic [1:0]   sh_r;
  acc_t         acc_r;
  logic [31:0]  sel_a, sel_b;
  logic [1:0]   sel_sh;
  acc_t         term;

  always_comb begin
    case (ph_r[1:0])
      2'd0:    begin sel_a = a_r[31:0];  sel_b = b_r[31:0];  sel_sh = 2'd0; end
      2'd1:    begin sel_a = a_r[63:32]; sel_b = b_r[31:0];  sel_sh = 2'd1; end
      2'd2:    begin sel_a = a_r[31:0];  sel_b = b_r[63:32]; sel_sh = 2'd1; end
      default: begin sel_a = a_r[63:32]; sel_b = b_r[63:32]; sel_sh = 2'd2; end
    endcase
    term = ACC_W'({40'd0, p_r}) << {sh_r, 5'd0};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      ph_r   <= '0;
    end else begin
      done_r <= 1'b0;
      if (ctl.start) begin
        a_r    <= op_a;
        b_r    <= op_b;
        neg_r  <= ctl.neg;
        ph_r   <= '0;
        busy_r <= 1'b1;
      end else if (busy_r) begin
        ph_r <= ph_r + 3'd1;
        if (ph_r == 3'd4) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (busy_r && ph_r != 3'd4) begin
      p_r  <= 64'(sel_a * sel_b);
      sh_r <= sel_sh;
    end
    if (ctl.clear) begin
      acc_r <= '0;
    end else if (busy_r && ph_r != 3'd0) begin
      acc_r <= neg_r ? (acc_r - term) : (acc_r + term);
    end
  end

  assign acc  = acc_r;
  assign done = done_r;

endmodule

[hw/rtl/pcp_isqrt.sv]
// Iterative integer square root of a 64-bit value, one result bit per cycle.
module pcp_isqrt (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [63:0] din,
  output logic [31:0] root,
  output logic        done
);
  import pcp_pkg::*;

  logic [63:0] x_r, res_r, bit_r;
  logic [4:0]  cnt_r;
  logic        busy_r, done_r;
  logic [63:0] trial;

  assign trial = res_r + bit_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 5'd1;
        if (cnt_r == 5'd31) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      x_r   <= din;
      res_r <= '0;
      bit_r <= 64'h4000_0000_0000_0000;
    end else if (busy_r) begin
      if (x_r >= trial) begin
        x_r   <= x_r - trial;
        res_r <= (res_r >> 1) + bit_r;
      end else begin
        res_r <= res_r >> 1;
      end
      bit_r <= bit_r >> 2;
    end
  end

  assign root = res_r[31:0];
  assign done = done_r;

endmodule

[sim/polyline_closest_point_test.sv]
// Testbench for polyline_closest_point: drives stimulus and checks each result item.
`timescale 1ns / 100ps

module polyline_closest_point_test;
  import pcp_pkg::*;

  localparam int STORE_DEPTH = 256;
  localparam int MAX_GAP     = 14;
  localparam int IDLE_TAIL   = 120;      // longer than an append plus the output stage
  localparam int STALL_LIMIT = 100000;   // well above the time a 256-vertex query needs
  localparam int RAND_ITEMS  = 1900;

  typedef logic signed [127:0] wide_t;

  typedef struct packed {
    logic        line_valid;
    logic [7:0]  seg_index;
    logic [16:0] seg_frac;
    logic [62:0] dist_sq;
    logic [31:0] dist_res;
    logic [31:0] arc_pos;
  } hit_t;

  // Integer square root, floor, 64-bit input.
  function automatic logic [63:0] int_sqrt(input logic [63:0] x);
    logic [63:0] res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > x) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (x >= res + bitv) begin
        x = x - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  // Shadow copy of the polyline store; predicts query results.
  class polyline_predictor;
    logic signed [31:0] vx[STORE_DEPTH];
    logic signed [31:0] vy[STORE_DEPTH];
    logic signed [31:0] vz[STORE_DEPTH];
    logic [31:0]        cum_len[STORE_DEPTH];
    int                 count;
    bit                 closed_loop;
    hit_t               expected_hits[$];
    int                 errors;

    function void wipe();
      count = 0;
      closed_loop = 0;
      errors = 0;
      expected_hits.delete();
    endfunction

    function logic [63:0] seg_length(int i, int j);
      longint d;
      wide_t  s;
      s = 0;
      d = longint'(vx[j]) - longint'(vx[i]); s += wide_t'(d) * wide_t'(d);
      d = longint'(vy[j]) - longint'(vy[i]); s += wide_t'(d) * wide_t'(d);
      d = longint'(vz[j]) - longint'(vz[i]); s += wide_t'(d) * wide_t'(d);
      if (s[127:64] != 0) return 64'(M32);
      return int_sqrt(s[63:0]);
    endfunction

    // Project q onto segment i->j; t is Q1.16, dsum the squared error sum.
    function void project(int i, int j, longint q[3], output logic [16:0] t,
                          output wide_t dsum);
      longint d[3], w[3], e;
      wide_t  len, dot;
      len = 0; dot = 0; dsum = 0; t = 0;
      d[0] = longint'(vx[j]) - longint'(vx[i]); w[0] = q[0] - longint'(vx[i]);
      d[1] = longint'(vy[j]) - longint'(vy[i]); w[1] = q[1] - longint'(vy[i]);
      d[2] = longint'(vz[j]) - longint'(vz[i]); w[2] = q[2] - longint'(vz[i]);
      for (int k = 0; k < 3; k++) begin
        len += wide_t'(d[k]) * wide_t'(d[k]);
        dot += wide_t'(d[k]) * wide_t'(w[k]);
      end
      // degenerate segment keeps t at 0
      if (len != 0 && dot > 0) begin
        if (dot >= len) t = T_ONE;
        else t = 17'((dot <<< 16) / len);
      end
      for (int k = 0; k < 3; k++) begin
        e = w[k] * 65536 - d[k] * longint'(t);
        dsum += wide_t'(e) * wide_t'(e);
      end
    endfunction

    function void note_item(logic [1:0] cmd, logic signed [31:0] x,
                            logic signed [31:0] y, logic signed [31:0] z);
      hit_t        h;
      longint      q[3];
      int          nseg, best_i, nxt;
      logic [16:0] t, best_t;
      wide_t       s, best_s, sq;
      logic [63:0] seglen, arc;
      case (cmd)
        CMD_CLEAR: count = 0;
        CMD_APPEND: begin
          if (count < STORE_DEPTH) begin
            vx[count] = x; vy[count] = y; vz[count] = z;
            if (count == 0) begin
              cum_len[0] = 0;
            end else begin
              arc = 64'(cum_len[count-1]) + seg_length(count - 1, count);
              cum_len[count] = (arc > 64'(M32)) ? M32 : arc[31:0];
            end
            count++;
          end
        end
        CMD_QUERY: begin
          h = '0;
          if (count >= 2) begin
            q[0] = x; q[1] = y; q[2] = z;
            nseg = count - 1 + (closed_loop ? 1 : 0);
            best_i = 0; best_t = 0; best_s = 0;
            for (int i = 0; i < nseg; i++) begin
              nxt = (i + 1 < count) ? i + 1 : 0;
              project(i, nxt, q, t, s);
              // strict compare: ties go to the lower index
              if (i == 0 || s < best_s) begin
                best_s = s; best_i = i; best_t = t;
              end
            end
            if (best_i + 1 < count) seglen = 64'(cum_len[best_i+1]) - 64'(cum_len[best_i]);
            else seglen = seg_length(count - 1, 0);
            arc = 64'(cum_len[best_i]) + ((seglen * 64'(best_t)) >> 16);
            sq = best_s >>> 32;
            h.line_valid = 1;
            h.seg_index  = best_i[7:0];
            h.seg_frac   = best_t;
            h.dist_sq    = (sq > wide_t'(SQ_MAX)) ? SQ_MAX : sq[62:0];
            h.dist_res   = (sq[127:64] != 0) ? M32 : 32'(int_sqrt(sq[63:0]));
            h.arc_pos    = (arc > 64'(M32)) ? M32 : arc[31:0];
          end
          expected_hits.push_back(h);
        end
        default: ;  // unused command: ignored
      endcase
    endfunction

    function void check_hit(hit_t got);
      hit_t want;
      if (expected_hits.size() == 0) begin
        $error("unexpected result item: %p", got);
        errors++;
        return;
      end
      want = expected_hits.pop_front();
      if (got.line_valid != want.line_valid) begin
        $error("line_valid: expected %0d got %0d", want.line_valid, got.line_valid); errors++;
      end
      if (got.seg_index != want.seg_index) begin
        $error("seg_index: expected %0d got %0d", want.seg_index, got.seg_index); errors++;
      end
      if (got.seg_frac != want.seg_frac) begin
        $error("seg_frac: expected %0d got %0d", want.seg_frac, got.seg_frac); errors++;
      end
      if (got.dist_sq != want.dist_sq) begin
        $error("dist_sq: expected %0d got %0d", want.dist_sq, got.dist_sq); errors++;
      end
      if (got.dist_res != want.dist_res) begin
        $error("dist_res: expected %0d got %0d", want.dist_res, got.dist_res); errors++;
      end
      if (got.arc_pos != want.arc_pos) begin
        $error("arc_pos: expected %0d got %0d", want.arc_pos, got.arc_pos); errors++;
      end
    endfunction
  endclass

  logic               clk = 0;
  logic               rst_n = 0;
  logic               cfg_wr_en = 0;
  logic               cfg_wr_data = 0;
  logic               in_valid = 0;
  logic               in_ready;
  logic [1:0]         in_cmd = CMD_CLEAR;
  logic signed [31:0] in_point_x = 0;
  logic signed [31:0] in_point_y = 0;
  logic signed [31:0] in_point_z = 0;
  logic               out_valid;
  logic               out_ready = 0;
  logic               out_line_valid;
  logic [7:0]         out_seg_index;
  logic [16:0]        out_seg_frac;
  logic [62:0]        out_dist_sq;
  logic [31:0]        out_dist_res;
  logic [31:0]        out_arc_pos;

  polyline_closest_point dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .in_valid(in_valid), .in_ready(in_ready), .in_cmd(in_cmd),
    .in_point_x(in_point_x), .in_point_y(in_point_y), .in_point_z(in_point_z),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_line_valid(out_line_valid), .out_seg_index(out_seg_index),
    .out_seg_frac(out_seg_frac), .out_dist_sq(out_dist_sq),
    .out_dist_res(out_dist_res), .out_arc_pos(out_arc_pos)
  );

  always begin
    #1 clk = 1;
    #1 clk = 0;
  end

  polyline_predictor shadow = new();
  bit  send_calm;      // when set, the sender issues back-to-back items
  bit  recv_calm;      // when set, the receiver never stalls
  int  recv_wait;
  int  quiet_cycles;
  int  items_sent;

  // Result side: sample at the edge, draw a fresh stall after every item.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 0;
      recv_wait = 0;
    end else if (out_valid && out_ready) begin
      shadow.check_hit({out_line_valid, out_seg_index, out_seg_frac,
                        out_dist_sq, out_dist_res, out_arc_pos});
      if ($urandom_range(0, 29) == 0) recv_calm = !recv_calm;
      recv_wait = recv_calm ? 0 : $urandom_range(0, MAX_GAP);
      out_ready <= (recv_wait == 0);
    end else if (recv_wait > 0) begin
      recv_wait--;
      out_ready <= (recv_wait == 0);
    end else begin
      out_ready <= 1;
    end
  end

  // Watchdog: end the run when nothing moves for too long.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Present one item after a random gap, hold it until accepted.
  // Returns on the accepting edge so the caller may drive the next item there.
  task automatic send_item(logic [1:0] cmd, logic signed [31:0] x,
                           logic signed [31:0] y, logic signed [31:0] z);
    int gap;
    if ($urandom_range(0, 49) == 0) send_calm = !send_calm;
    gap = send_calm ? 0 : $urandom_range(0, MAX_GAP);
    if (gap > 0) begin
      in_valid <= 0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1;
    in_cmd     <= cmd;
    in_point_x <= x;
    in_point_y <= y;
    in_point_z <= z;
    do @(posedge clk); while (!in_ready);
    shadow.note_item(cmd, x, y, z);
    items_sent++;
  endtask

  // Drop valid, wait until every expected result is back, then let the
  // block finish any append still in flight.
  task automatic drain();
    in_valid <= 0;
    while (shadow.expected_hits.size() != 0) @(posedge clk);
    repeat (IDLE_TAIL) @(posedge clk);
  endtask

  // Write closed_loop; called after reset or after drain().
  task automatic write_loop(bit v);
    cfg_wr_en   <= 1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 0;
    shadow.closed_loop = v;
  endtask

  // Coordinate mix: extremes, full-range words, and a dense middle band.
  function automatic logic signed [31:0] pick_coord();
    case ($urandom_range(0, 9))
      0:       return 32'sh7fff_ffff;
      1:       return 32'sh8000_0000;
      2, 3:    return $urandom;
      4:       return $signed($urandom_range(0, 32'h7f_ffff)) - 32'sh40_0000;
      default: return $signed($urandom_range(0, 32'h3f_ffff)) - 32'sh20_0000;
    endcase
  endfunction

  // One well-formed sequence: clear, a short polyline, several queries,
  // sprinkled with noise (unused command, stray append).
  task automatic random_polyline();
    int nv, nq;
    logic signed [31:0] px, py, pz;
    send_item(CMD_CLEAR, $urandom, $urandom, $urandom);
    nv = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 1) : $urandom_range(2, 8);
    px = pick_coord(); py = pick_coord(); pz = pick_coord();
    for (int i = 0; i < nv; i++) begin
      // repeat a vertex now and then to give a degenerate segment
      if (i == 0 || $urandom_range(0, 7) != 0) begin
        px = pick_coord(); py = pick_coord(); pz = pick_coord();
      end
      send_item(CMD_APPEND, px, py, pz);
    end
    nq = $urandom_range(1, 6);
    for (int i = 0; i < nq; i++) begin
      case ($urandom_range(0, 11))
        0:       send_item(2'd3, $urandom, $urandom, $urandom);
        1:       send_item(CMD_APPEND, pick_coord(), pick_coord(), pick_coord());
        default: send_item(CMD_QUERY, pick_coord(), pick_coord(), pick_coord());
      endcase
    end
  endtask

  initial begin
    shadow.wipe();
    send_calm = 0;
    recv_calm = 0;
    items_sent = 0;
    quiet_cycles = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    write_loop(0);

    // Directed: short polylines, unused command, extremes, ties, degenerate.
    send_item(CMD_QUERY, 0, 0, 0);
    send_item(CMD_APPEND, 32'sh0001_0000, 0, 0);
    send_item(CMD_QUERY, 0, 0, 0);
    send_item(2'd3, 32'sh7fff_ffff, 32'sh8000_0000, 32'sh7fff_ffff);
    send_item(CMD_APPEND, 32'sh0001_0000, 0, 0);            // degenerate segment
    send_item(CMD_APPEND, 32'sh0003_0000, 0, 0);
    send_item(CMD_APPEND, 32'sh0003_0000, 32'sh0002_0000, 0);
    send_item(CMD_QUERY, 32'sh0003_0000, 0, 0);             // tie at shared vertex
    send_item(CMD_QUERY, 32'sh0002_0000, 32'sh0001_0000, 0); // tie between two segments
    send_item(CMD_QUERY, -32'sh0005_0000, 0, 0);            // clamp t to 0
    send_item(CMD_QUERY, 32'sh0009_0000, 32'sh0009_0000, 0); // clamp t to end
    send_item(CMD_APPEND, 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000);
    send_item(CMD_APPEND, 32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff);
    send_item(CMD_QUERY, 32'sh8000_0000, 32'sh7fff_ffff, 32'sh8000_0000);
    send_item(CMD_QUERY, 32'sh7fff_ffff, 32'sh8000_0000, 32'sh7fff_ffff);
    send_item(CMD_CLEAR, 0, 0, 0);
    send_item(CMD_QUERY, 32'sh1234_5678, 0, 0);
    send_item(CMD_APPEND, 0, 0, 0);
    send_item(CMD_APPEND, 32'sh0004_0000, 32'sh0004_0000, 32'sh0004_0000);
    drain();
    write_loop(1);
    // two-vertex loop: the closing segment runs back over the same line
    send_item(CMD_QUERY, 32'sh0002_0000, 32'sh0002_0000, 32'sh0001_0000);
    send_item(CMD_QUERY, -32'sh0001_0000, 0, 0);
    send_item(CMD_APPEND, 32'sh0004_0000, 0, 0);
    send_item(CMD_QUERY, 32'sh0002_0000, 0, 0);            // nearest on the closing segment
    drain();

    // Random part in phases, switching the loop setting between them.
    for (int phase = 0; phase < 4; phase++) begin
      write_loop(phase[0]);
      if (phase == 2) begin
        // fill the store past capacity; surplus appends are dropped
        send_item(CMD_CLEAR, 0, 0, 0);
        for (int i = 0; i < STORE_DEPTH + 2; i++)
          send_item(CMD_APPEND, pick_coord() >>> 6, pick_coord() >>> 6, pick_coord() >>> 6);
        send_item(CMD_QUERY, pick_coord(), pick_coord(), pick_coord());
        drain();
        write_loop(1);
        send_item(CMD_QUERY, pick_coord(), pick_coord(), pick_coord());
        drain();
        write_loop(0);
      end
      while (items_sent < (phase + 1) * RAND_ITEMS / 4) begin
        random_polyline();
        // hold off once in a while until all answers are back
        if ($urandom_range(0, 19) == 0) drain();
      end
      drain();
    end

    if (shadow.errors == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

endmodule
